// ===== hdl/rx_descriptor_reassembly_defines.svh =====
// Assertion helpers for the receive descriptor reassembly checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RX_DESCRIPTOR_REASSEMBLY_DEFINES_SVH
`define RX_DESCRIPTOR_REASSEMBLY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RXDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RXDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rxdr_pkg.sv =====
package rxdr_pkg;

  // Bit that flags a receive error in the status word.
  localparam int ERROR_BIT = 21;
  // Largest ring the position counter supports.
  localparam int MAX_RING  = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [19:0] LEN_MAX   = 20'hFFFFF;
  localparam logic [7:0]  SEG_MAX   = 8'hFF;
  localparam logic [13:0] CRC_BYTES = 14'd4;

  localparam logic [13:0] BUFFER_SIZE_RESET    = 14'd2048;
  localparam logic [12:0] RING_ENTRIES_RESET   = 13'd256;
  localparam logic [15:0] FREE_THRESHOLD_RESET = 16'd32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHECKSUM_OFFLOAD = 3'd0,
    CFG_SCATTER_MODE     = 3'd1,
    CFG_BUFFER_SIZE      = 3'd2,
    CFG_RING_ENTRIES     = 3'd3,
    CFG_FREE_THRESHOLD   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUTCOME_OWNED    = 2'd0,
    OUTCOME_ERROR    = 2'd1,
    OUTCOME_FRAGMENT = 2'd2,
    OUTCOME_COMPLETE = 2'd3
  } outcome_t;

  typedef struct packed {
    logic        checksum_offload;
    logic        scatter_mode;
    logic [13:0] buffer_size;
    logic [12:0] ring_entries;
    logic [15:0] free_threshold;
  } cfg_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [11:0] descriptor_index;
    logic [31:0] rearm_word;
    logic [19:0] packet_length;
    logic [7:0]  segment_total;
    logic [13:0] last_segment_length;
    logic        vlan_present;
    logic [15:0] vlan_tag;
    logic        ip_checksum_good;
    logic        l4_checksum_good;
    logic        clear_interrupt;
  } result_t;

endpackage

// ===== hdl/rxdr_if.sv =====
interface rxdr_desc_if;
  logic        valid;
  logic        ready;
  logic [31:0] status_word;
  logic [31:0] extra_word;

  modport source (output valid, output status_word, output extra_word, input ready);
  modport sink (input valid, input status_word, input extra_word, output ready);
endinterface

interface rxdr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [11:0] descriptor_index;
  logic [31:0] rearm_word;
  logic [19:0] packet_length;
  logic [7:0]  segment_total;
  logic [13:0] last_segment_length;
  logic        vlan_present;
  logic [15:0] vlan_tag;
  logic        ip_checksum_good;
  logic        l4_checksum_good;
  logic        clear_interrupt;

  modport source (
    output valid, output outcome, output descriptor_index, output rearm_word,
    output packet_length, output segment_total, output last_segment_length,
    output vlan_present, output vlan_tag, output ip_checksum_good,
    output l4_checksum_good, output clear_interrupt, input ready
  );
  modport sink (
    input valid, input outcome, input descriptor_index, input rearm_word,
    input packet_length, input segment_total, input last_segment_length,
    input vlan_present, input vlan_tag, input ip_checksum_good,
    input l4_checksum_good, input clear_interrupt, output ready
  );
endinterface

// ===== hdl/rxdr_cfg_regs.sv =====
module rxdr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rxdr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rxdr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rxdr_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.checksum_offload <= 1'b0;
      cfg.scatter_mode     <= 1'b0;
      cfg.buffer_size      <= rxdr_pkg::BUFFER_SIZE_RESET;
      cfg.ring_entries     <= rxdr_pkg::RING_ENTRIES_RESET;
      cfg.free_threshold   <= rxdr_pkg::FREE_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rxdr_pkg::CFG_CHECKSUM_OFFLOAD: cfg.checksum_offload <= cfg_data[0];
        rxdr_pkg::CFG_SCATTER_MODE:     cfg.scatter_mode     <= cfg_data[0];
        rxdr_pkg::CFG_BUFFER_SIZE:      cfg.buffer_size      <= cfg_data[13:0];
        rxdr_pkg::CFG_RING_ENTRIES:     cfg.ring_entries     <= cfg_data[12:0];
        rxdr_pkg::CFG_FREE_THRESHOLD:   cfg.free_threshold   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rxdr_engine.sv =====
module rxdr_engine (
  input  logic              clk,
  input  logic              rst,
  input  rxdr_pkg::cfg_t    cfg,
  input  logic              fire,
  input  logic [31:0]       status_word,
  input  logic [31:0]       extra_word,
  output rxdr_pkg::result_t res
);

  logic        in_packet;
  logic [19:0] accumulated_length;
  logic [7:0]  segment_count;
  logic [13:0] previous_segment_length;
  logic [11:0] ring_position;
  logic [15:0] hold_count;

  logic        in_packet_next;
  logic [19:0] accumulated_length_next;
  logic [7:0]  segment_count_next;
  logic [13:0] previous_segment_length_next;
  logic [11:0] ring_position_next;
  logic [15:0] hold_count_next;

  logic        owned, errored, last_frag, complete;
  logic [13:0] dlen, cut;
  logic [16:0] ring_limit, pos_inc;
  logic [15:0] hold_inc;
  logic [20:0] acc_sum;
  logic [19:0] acc_new;
  logic [7:0]  seg_new;

  assign owned     = status_word[31];
  assign errored   = status_word[rxdr_pkg::ERROR_BIT];
  assign last_frag = status_word[28];
  assign dlen      = status_word[13:0];
  assign cut       = rxdr_pkg::CRC_BYTES - dlen;

  // Ring wrap: out-of-range ring sizes behave as the largest ring.
  always_comb begin
    if (cfg.ring_entries == 13'd0 || 17'(cfg.ring_entries) > 17'(rxdr_pkg::MAX_RING)) begin
      ring_limit = 17'(rxdr_pkg::MAX_RING);
    end else begin
      ring_limit = 17'(cfg.ring_entries);
    end
    pos_inc = 17'(ring_position) + 17'd1;
  end

  assign hold_inc = (hold_count != 16'hFFFF) ? hold_count + 16'd1 : hold_count;

  // Chain accumulation for scatter mode, saturating.
  always_comb begin
    acc_sum = 21'(accumulated_length) + 21'(dlen);
    if (!in_packet) begin
      acc_new = 20'(dlen);
      seg_new = 8'd1;
    end else begin
      acc_new = acc_sum[20] ? rxdr_pkg::LEN_MAX : acc_sum[19:0];
      seg_new = (segment_count != rxdr_pkg::SEG_MAX) ? segment_count + 8'd1 : segment_count;
    end
  end

  always_comb begin
    in_packet_next               = in_packet;
    accumulated_length_next      = accumulated_length;
    segment_count_next           = segment_count;
    previous_segment_length_next = previous_segment_length;
    ring_position_next           = ring_position;
    hold_count_next              = hold_count;
    complete                     = 1'b0;

    res                  = '0;
    res.outcome          = rxdr_pkg::OUTCOME_OWNED;
    res.descriptor_index = ring_position;

    if (!owned) begin
      res.rearm_word     = {1'b1, status_word[30], 16'd0, cfg.buffer_size};
      ring_position_next = (pos_inc >= ring_limit) ? 12'd0 : pos_inc[11:0];
      hold_count_next    = hold_inc;
      if (errored) begin
        res.outcome = rxdr_pkg::OUTCOME_ERROR;
      end else if (!cfg.scatter_mode) begin
        res.packet_length       = (dlen > rxdr_pkg::CRC_BYTES) ?
                                  20'(dlen - rxdr_pkg::CRC_BYTES) : 20'd0;
        res.segment_total       = 8'd1;
        res.last_segment_length = res.packet_length[13:0];
        complete                = 1'b1;
      end else if (!last_frag) begin
        in_packet_next               = 1'b1;
        accumulated_length_next      = acc_new;
        segment_count_next           = seg_new;
        previous_segment_length_next = dlen;
        res.outcome                  = rxdr_pkg::OUTCOME_FRAGMENT;
      end else begin
        if (acc_new == rxdr_pkg::LEN_MAX) begin
          res.packet_length = rxdr_pkg::LEN_MAX;
        end else if (acc_new > 20'(rxdr_pkg::CRC_BYTES)) begin
          res.packet_length = acc_new - 20'(rxdr_pkg::CRC_BYTES);
        end else begin
          res.packet_length = 20'd0;
        end
        res.segment_total = seg_new;
        if (dlen <= rxdr_pkg::CRC_BYTES) begin
          // The last fragment holds only CRC bytes: drop it and trim the one before.
          if (seg_new <= 8'd1) begin
            res.segment_total       = 8'd0;
            res.packet_length       = 20'd0;
            res.last_segment_length = 14'd0;
          end else begin
            if (seg_new != rxdr_pkg::SEG_MAX) begin
              res.segment_total = seg_new - 8'd1;
            end
            res.last_segment_length = (previous_segment_length > cut) ?
                                      previous_segment_length - cut : 14'd0;
          end
        end else begin
          res.last_segment_length = dlen - rxdr_pkg::CRC_BYTES;
        end
        in_packet_next          = 1'b0;
        accumulated_length_next = 20'd0;
        segment_count_next      = 8'd0;
        complete                = 1'b1;
      end
    end

    if (complete) begin
      res.outcome      = rxdr_pkg::OUTCOME_COMPLETE;
      res.vlan_present = extra_word[16];
      res.vlan_tag     = extra_word[16] ? {extra_word[7:0], extra_word[15:8]} : 16'd0;
      if (cfg.checksum_offload) begin
        res.ip_checksum_good = (extra_word[30] && !status_word[16]) || extra_word[31];
        res.l4_checksum_good = res.ip_checksum_good &&
                               ((status_word[17] && !status_word[14]) ||
                                (status_word[18] && !status_word[15]));
      end
    end

    // Threshold check runs on every descriptor, owned ones included.
    if (hold_count_next > cfg.free_threshold) begin
      res.clear_interrupt = 1'b1;
      hold_count_next     = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet               <= 1'b0;
      accumulated_length      <= 20'd0;
      segment_count           <= 8'd0;
      previous_segment_length <= 14'd0;
      ring_position           <= 12'd0;
      hold_count              <= 16'd0;
    end else if (fire) begin
      in_packet               <= in_packet_next;
      accumulated_length      <= accumulated_length_next;
      segment_count           <= segment_count_next;
      previous_segment_length <= previous_segment_length_next;
      ring_position           <= ring_position_next;
      hold_count              <= hold_count_next;
    end
  end

endmodule

// ===== hdl/rx_descriptor_reassembly.sv =====
// Receive descriptor completion processing.
// The desc channel carries one completed receive descriptor per transfer: the
// status word and the extra word. The result channel returns exactly one word
// per descriptor, in order: outcome, ring index, re-arm word, packet totals,
// VLAN and checksum flags, and the clear-interrupt pulse.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, one register per cycle. The user must write them only while no
// descriptor is in flight; the block itself does not enforce this.
// A descriptor in the input register is processed by the engine and its result
// registered as the engine consumes it, updating the chain state, ring position
// and hold counter. One descriptor is taken per cycle while results are taken.
// Reset clears the pipeline, the chain state, the ring position and the hold
// counter, and loads the registers with their default values.
// When the receiver stalls, the result stays in the output register and one
// more descriptor can still be taken into the input register; after that the
// desc channel drops ready until the result is taken.
module rx_descriptor_reassembly (
  input  logic                               clk,
  input  logic                               rst,
  rxdr_desc_if.sink                          desc,
  rxdr_result_if.source                      result,
  input  logic                               cfg_write,
  input  logic [rxdr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rxdr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rxdr_pkg::cfg_t    cfg;
  rxdr_pkg::result_t engine_res;
  rxdr_pkg::result_t res_reg;

  // Input register stage.
  logic        s1_valid;
  logic [31:0] s1_status;
  logic [31:0] s1_extra;
  logic        res_valid;
  logic        advance;

  // The engine consumes the input stage whenever the output register is free
  // or is being emptied in this cycle.
  assign advance    = s1_valid && (!res_valid || result.ready);
  assign desc.ready = !s1_valid || advance;

  rxdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rxdr_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fire        (advance),
    .status_word (s1_status),
    .extra_word  (s1_extra),
    .res         (engine_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (desc.valid && desc.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (desc.valid && desc.ready) begin
      s1_status <= desc.status_word;
      s1_extra  <= desc.extra_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= engine_res;
    end
  end

  assign result.valid               = res_valid;
  assign result.outcome             = res_reg.outcome;
  assign result.descriptor_index    = res_reg.descriptor_index;
  assign result.rearm_word          = res_reg.rearm_word;
  assign result.packet_length       = res_reg.packet_length;
  assign result.segment_total       = res_reg.segment_total;
  assign result.last_segment_length = res_reg.last_segment_length;
  assign result.vlan_present        = res_reg.vlan_present;
  assign result.vlan_tag            = res_reg.vlan_tag;
  assign result.ip_checksum_good    = res_reg.ip_checksum_good;
  assign result.l4_checksum_good    = res_reg.l4_checksum_good;
  assign result.clear_interrupt     = res_reg.clear_interrupt;

endmodule

// ===== hdl/rxdr_checker.sv =====
`include "rx_descriptor_reassembly_defines.svh"

module rxdr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic [31:0] rearm_word,
  input logic [19:0] packet_length,
  input logic [7:0]  segment_total,
  input logic        vlan_present,
  input logic        ip_checksum_good,
  input logic        l4_checksum_good
);

  logic owned_out, complete_out;

  assign owned_out    = out_valid && (outcome == rxdr_pkg::OUTCOME_OWNED);
  assign complete_out = out_valid && (outcome == rxdr_pkg::OUTCOME_COMPLETE);

  `RXDR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(rearm_word), "result changed while stalled")
  `RXDR_ASSERT_SAME(a_owned_no_rearm, owned_out, rearm_word == 32'd0, "owned descriptor was re-armed")
  `RXDR_ASSERT_SAME(a_totals_only_complete, out_valid && !complete_out, packet_length == 20'd0 && segment_total == 8'd0 && !vlan_present && !ip_checksum_good, "packet totals on a non-complete result")
  `RXDR_ASSERT_SAME(a_l4_needs_ip, out_valid && l4_checksum_good, ip_checksum_good, "L4 checksum good without IP checksum good")

endmodule

bind rx_descriptor_reassembly rxdr_checker u_rxdr_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .outcome          (result.outcome),
  .rearm_word       (result.rearm_word),
  .packet_length    (result.packet_length),
  .segment_total    (result.segment_total),
  .vlan_present     (result.vlan_present),
  .ip_checksum_good (result.ip_checksum_good),
  .l4_checksum_good (result.l4_checksum_good)
);
